// ===== rtl/ctat_pkg.sv =====
// Shared constants, types and codes for the connection table with aging.
package ctat_pkg;

   localparam int ENTRIES     = 16;
   localparam int KEY_BITS    = 64;
   localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int STAMP_BITS  = 32;
   localparam int OWNER_BITS  = 64;
   localparam int ENTRY_BITS  = KEY_BITS + STAMP_BITS + OWNER_BITS;
   localparam int PEER_BITS   = 64;
   localparam int REQ_DATA_BITS = PEER_BITS + OWNER_BITS + STAMP_BITS;
   localparam int SLOT_BITS   = 4;
   localparam int STATUS_BITS = 2;
   localparam int RSP_DATA_BITS = 8;
   localparam logic [STAMP_BITS-1:0] TIMEOUT_RESET = 32'd10000;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_DROP   = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_SWEEP  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK      = 2'd0,
      STAT_PRESENT = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_ABSENT  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

endpackage

// ===== rtl/ctat_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ctat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/connection_table_with_aging.sv =====
// Top level of the connection table with timeout aging.
//
// Usage: each request beat on req_* carries one command (add, drop, lookup or
// sweep) in req_tuser and the peer key, owner id and current time in
// req_tdata. Every request yields exactly one response beat on rsp_* with a
// status and a slot number. The idle timeout is written through csr_*; the
// user must write it only while no request is in flight, as the block itself does not enforce this.
// Sequence: a request is taken in the idle state, then every one of the
// ENTRIES slots is read from the entry RAM, one slot per cycle, a drain
// state covers the read latency of the last slot, and a finish state updates
// the table and loads the response register. The block takes no new request
// until it is through with the current one; the slot scan through the
// single read port of the entry RAM sets how long an item occupies it.
// The response sits in an output register, so the next request is accepted
// while a response still waits to be taken. If the receiver stalls, the next
// command finishes its scan and then holds before its table update until the
// response register is free; no response is lost or reordered.
// Reset clears all valid bits, restores the timeout to 10000 ms and returns
// the sequencer to idle; the RAM contents are never read without a valid bit.
module connection_table_with_aging (
   input  logic                               clock,
   input  logic                               reset,
   // Request tdata, from the lowest bit up: peer_key, owner_id, now_ms.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ctat_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // Request tuser: command.
   input  logic [1:0]                         req_tuser,
   // Response tdata, from the lowest bit up: status, slot, zero fill.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ctat_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // Timeout register write channel.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ctat_pkg::STAMP_BITS-1:0]    csr_data
);
   import ctat_pkg::*;

   // Sequencer and request registers.
   state_type                state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]      key_ff, key_in;
   logic [OWNER_BITS-1:0]    owner_ff, owner_in;
   logic [STAMP_BITS-1:0]    now_ff, now_in;
   logic [STAMP_BITS-1:0]    timeout_ff, timeout_in;

   // Scan pipeline: the read address and the slot whose data is on the RAM output.
   logic [IDX_BITS-1:0]      rd_idx_ff, rd_idx_in;
   logic [IDX_BITS-1:0]      chk_idx_ff, chk_idx_in;
   logic                     chk_vld_ff, chk_vld_in;

   // Search results gathered during the scan.
   logic                     hit_ff, hit_in;
   logic [IDX_BITS-1:0]      hit_idx_ff, hit_idx_in;
   logic                     free_ff, free_in;
   logic [IDX_BITS-1:0]      free_idx_ff, free_idx_in;

   logic [ENTRIES-1:0]       valid_ff, valid_in;

   // Response register.
   logic                     rsp_vld_ff, rsp_vld_in;
   status_type               status_ff, status_in;
   logic [SLOT_BITS-1:0]     slot_ff, slot_in;

   // RAM ports.
   logic                     wr_en;
   logic [IDX_BITS-1:0]      wr_addr;
   logic [ENTRY_BITS-1:0]    wr_data;
   logic [ENTRY_BITS-1:0]    rd_data;

   // Fields of the entry on the RAM output.
   logic                     ent_vld;
   logic [KEY_BITS-1:0]      ent_key;
   logic [STAMP_BITS-1:0]    ent_stamp;
   logic [STAMP_BITS-1:0]    ent_expiry;
   logic                     rsp_free;

   // One entry word is {owner, stamp, key}, key in the lowest bits.
   ctat_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(ENTRIES)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_idx_ff),
      .rd_data(rd_data)
   );

   assign ent_vld    = valid_ff[chk_idx_ff];
   assign ent_key    = rd_data[KEY_BITS-1:0];
   assign ent_stamp  = rd_data[KEY_BITS +: STAMP_BITS];
   // The sum wraps at 32 bits, so an entry near the top of the clock range
   // can expire early.
   assign ent_expiry = STAMP_BITS'(ent_stamp + timeout_ff);
   assign rsp_free   = !rsp_vld_ff || rsp_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({slot_ff, status_ff});

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      key_in      = key_ff;
      owner_in    = owner_ff;
      now_in      = now_ff;
      timeout_in  = timeout_ff;
      rd_idx_in   = rd_idx_ff;
      chk_idx_in  = chk_idx_ff;
      chk_vld_in  = 1'b0;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      valid_in    = valid_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      status_in   = status_ff;
      slot_in     = slot_ff;
      wr_en       = 1'b0;
      wr_addr     = chk_idx_ff;
      wr_data     = '0;

      if (csr_valid) begin
         timeout_in = csr_data;
      end

      // Look at the slot whose data arrived from the RAM this cycle.
      if (chk_vld_ff) begin
         if (ent_vld && (ent_key == key_ff) && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = chk_idx_ff;
         end
         if (!ent_vld && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
         // Sweep clears expired entries as it passes them.
         if ((cmd_ff == CMD_SWEEP) && ent_vld && (ent_expiry < now_ff)) begin
            valid_in[chk_idx_ff] = 1'b0;
            wr_en                = 1'b1;
            wr_addr              = chk_idx_ff;
            wr_data              = '0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = cmd_type'(req_tuser);
               key_in    = req_tdata[KEY_BITS-1:0];
               owner_in  = req_tdata[PEER_BITS +: OWNER_BITS];
               now_in    = req_tdata[PEER_BITS + OWNER_BITS +: STAMP_BITS];
               rd_idx_in = '0;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            chk_vld_in = 1'b1;
            chk_idx_in = rd_idx_ff;
            if (rd_idx_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // Table update and response load happen together, once the
            // response register can take the result.
            if (rsp_free) begin
               rsp_vld_in = 1'b1;
               status_in  = STAT_OK;
               slot_in    = '0;
               state_in   = S_IDLE;
               unique case (cmd_ff)
                  CMD_ADD: begin
                     if (hit_ff) begin
                        status_in = STAT_PRESENT;
                        slot_in   = SLOT_BITS'(hit_idx_ff);
                     end else if (free_ff) begin
                        valid_in[free_idx_ff] = 1'b1;
                        wr_en     = 1'b1;
                        wr_addr   = free_idx_ff;
                        wr_data   = {owner_ff, now_ff, key_ff};
                        slot_in   = SLOT_BITS'(free_idx_ff);
                     end else begin
                        status_in = STAT_FULL;
                     end
                  end
                  CMD_DROP: begin
                     if (hit_ff) begin
                        valid_in[hit_idx_ff] = 1'b0;
                        wr_en     = 1'b1;
                        wr_addr   = hit_idx_ff;
                        wr_data   = '0;
                        slot_in   = SLOT_BITS'(hit_idx_ff);
                     end else begin
                        status_in = STAT_ABSENT;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (hit_ff) begin
                        slot_in   = SLOT_BITS'(hit_idx_ff);
                     end else begin
                        status_in = STAT_ABSENT;
                     end
                  end
                  CMD_SWEEP: begin
                     status_in = STAT_OK;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         timeout_ff <= TIMEOUT_RESET;
         valid_ff   <= '0;
         chk_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         timeout_ff <= timeout_in;
         valid_ff   <= valid_in;
         chk_vld_ff <= chk_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         hit_ff     <= hit_in;
         free_ff    <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      owner_ff    <= owner_in;
      now_ff      <= now_in;
      rd_idx_ff   <= rd_idx_in;
      chk_idx_ff  <= chk_idx_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      status_ff   <= status_in;
      slot_ff     <= slot_in;
   end
endmodule
